// ===== hdl/cau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic zdiv;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/cau_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cau_front #(
  parameter int W = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic [1:0]            req_type,
  input  wire logic signed [W-1:0]   a_re,
  input  wire logic signed [W-1:0]   a_im,
  input  wire logic signed [W-1:0]   b_re,
  input  wire logic signed [W-1:0]   b_im,
  output cau_pkg::ctrl_t             ctrl,
  output logic signed [W:0]          as_re,
  output logic signed [W:0]          as_im,
  output logic signed [2*W:0]        mre,
  output logic signed [2*W:0]        mim,
  output logic signed [2*W:0]        nr,
  output logic signed [2*W:0]        ni,
  output logic [2*W:0]               den
);

  cau_pkg::ctrl_t          ctrl1;
  logic signed [2*W-1:0]   p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [W:0]       s_re, s_im;
  cau_pkg::op_t            op_in;

  assign op_in = cau_pkg::op_t'(req_type);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1.valid <= 1'b0;
    end else begin
      ctrl1.valid <= take;
    end
    ctrl1.op   <= op_in;
    ctrl1.zdiv <= (op_in == cau_pkg::OP_DIV) && (b_re == '0) && (b_im == '0);
    p_rr <= a_re * b_re;
    p_ii <= a_im * b_im;
    p_ri <= a_re * b_im;
    p_ir <= a_im * b_re;
    p_bb <= b_re * b_re;
    p_cc <= b_im * b_im;
    if (op_in == cau_pkg::OP_SUB) begin
      s_re <= {a_re[W-1], a_re} - {b_re[W-1], b_re};
      s_im <= {a_im[W-1], a_im} - {b_im[W-1], b_im};
    end else begin
      s_re <= {a_re[W-1], a_re} + {b_re[W-1], b_re};
      s_im <= {a_im[W-1], a_im} + {b_im[W-1], b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= ctrl1.valid;
    end
    ctrl.op   <= ctrl1.op;
    ctrl.zdiv <= ctrl1.zdiv;
    as_re <= s_re;
    as_im <= s_im;
    mre <= {p_rr[2*W-1], p_rr} - {p_ii[2*W-1], p_ii};
    mim <= {p_ri[2*W-1], p_ri} + {p_ir[2*W-1], p_ir};
    nr  <= {p_rr[2*W-1], p_rr} + {p_ii[2*W-1], p_ii};
    ni  <= {p_ir[2*W-1], p_ir} - {p_ri[2*W-1], p_ri};
    den <= {1'b0, p_bb} + {1'b0, p_cc};
  end

endmodule
`default_nettype wire

// ===== hdl/cau_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cau_div_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                clk,
  input  wire logic signed [2*W:0] num,
  input  wire logic [2*W:0]        den,
  output logic signed [W-1:0]      quo,
  output logic                     ovf
);

  localparam int NW = 2 * W + 1 + F;
  localparam logic [W:0] HALF = {2'b01, {(W-1){1'b0}}};

  logic [2*W:0]  mag;
  logic [NW-1:0] nshift;
  logic [NW-1:0] hi;
  logic          big;

  logic [2*W:0] rem    [0:W+1];
  logic [W:0]   low    [0:W+1];
  logic [W:0]   quo_s  [0:W+1];
  logic [2*W:0] den_s  [0:W+1];
  logic         neg_s  [0:W+1];
  logic         big_s  [0:W+1];

  always_comb begin
    mag    = num[2*W] ? (~num + 1'b1) : num;
    nshift = NW'(mag) << F;
    hi     = nshift >> (W + 1);
    big    = hi >= NW'(den);
  end

  always_ff @(posedge clk) begin
    rem[0]   <= hi[2*W:0];
    low[0]   <= nshift[W:0];
    quo_s[0] <= '0;
    den_s[0] <= den;
    neg_s[0] <= num[2*W];
    big_s[0] <= big;
  end

  for (genvar k = 1; k <= W + 1; k++) begin : g_step
    logic [2*W+1:0] t;
    logic [2*W+2:0] d;
    logic           ge;

    always_comb begin
      t  = {rem[k-1], low[k-1][W]};
      d  = {1'b0, t} - {2'b00, den_s[k-1]};
      ge = !d[2*W+2];
    end

    always_ff @(posedge clk) begin
      rem[k]   <= ge ? d[2*W:0] : t[2*W:0];
      low[k]   <= {low[k-1][W-1:0], 1'b0};
      quo_s[k] <= {quo_s[k-1][W-1:0], ge};
      den_s[k] <= den_s[k-1];
      neg_s[k] <= neg_s[k-1];
      big_s[k] <= big_s[k-1];
    end
  end

  logic [W:0] q;
  logic [W:0] qn;

  always_comb begin
    q  = quo_s[W+1];
    qn = ~q + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (neg_s[W+1]) begin
      if (big_s[W+1] || (q > HALF)) begin
        quo <= {1'b1, {(W-1){1'b0}}};
        ovf <= 1'b1;
      end else begin
        quo <= qn[W-1:0];
        ovf <= 1'b0;
      end
    end else begin
      if (big_s[W+1] || (q >= HALF)) begin
        quo <= {1'b0, {(W-1){1'b1}}};
        ovf <= 1'b1;
      end else begin
        quo <= q[W-1:0];
        ovf <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/complex_arith_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A request is taken in any cycle with start high; busy is always low.
// A result word is registered through cau_front, the divider lanes and done.
// Throughput: one word per cycle, set by the fully pipelined restoring divider,
// which retires one quotient bit per stage; the receiver cannot stall.
// Synchronous reset clears all valid bits; no result is pending afterward.
module complex_arith_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    req_type,
  input  wire logic signed [DATA_WIDTH-1:0]  a_re,
  input  wire logic signed [DATA_WIDTH-1:0]  a_im,
  input  wire logic signed [DATA_WIDTH-1:0]  b_re,
  input  wire logic signed [DATA_WIDTH-1:0]  b_im,
  output logic                               done,
  output logic signed [DATA_WIDTH-1:0]       res_re,
  output logic signed [DATA_WIDTH-1:0]       res_im,
  output logic                               overflow_flag,
  output logic                               zero_divisor
);

  localparam int W = DATA_WIDTH;
  localparam int DL = W + 3;
  localparam logic signed [2*W:0] SMAX = {{(W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W:0] SMIN = {{(W+2){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] RMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] RMIN = {1'b1, {(W-1){1'b0}}};

  cau_pkg::ctrl_t       ctrl2;
  logic signed [W:0]    as_re, as_im;
  logic signed [2*W:0]  mre, mim, nr, ni;
  logic [2*W:0]         den;
  logic signed [W-1:0]  lre, lim;
  logic                 lre_ovf, lim_ovf;

  assign busy = 1'b0;

  cau_front #(.W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (start && !busy),
    .req_type (req_type),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .ctrl     (ctrl2),
    .as_re    (as_re),
    .as_im    (as_im),
    .mre      (mre),
    .mim      (mim),
    .nr       (nr),
    .ni       (ni),
    .den      (den)
  );

  cau_div_lane #(.W(W), .F(FRAC_BITS)) u_div_re (
    .clk (clk),
    .num (nr),
    .den (den),
    .quo (lre),
    .ovf (lre_ovf)
  );

  cau_div_lane #(.W(W), .F(FRAC_BITS)) u_div_im (
    .clk (clk),
    .num (ni),
    .den (den),
    .quo (lim),
    .ovf (lim_ovf)
  );

  logic signed [2*W:0] ext_re, ext_im;
  logic [W-1:0]        fre, fim;
  logic                fovf;

  always_comb begin
    unique case (ctrl2.op)
      cau_pkg::OP_MUL: begin
        ext_re = mre >>> FRAC_BITS;
        ext_im = mim >>> FRAC_BITS;
      end
      cau_pkg::OP_DIV: begin
        ext_re = '0;
        ext_im = '0;
      end
      default: begin
        ext_re = {{W{as_re[W]}}, as_re};
        ext_im = {{W{as_im[W]}}, as_im};
      end
    endcase
    fre  = (ext_re > SMAX) ? RMAX : (ext_re < SMIN) ? RMIN : ext_re[W-1:0];
    fim  = (ext_im > SMAX) ? RMAX : (ext_im < SMIN) ? RMIN : ext_im[W-1:0];
    fovf = (ext_re > SMAX) || (ext_re < SMIN) || (ext_im > SMAX) || (ext_im < SMIN);
  end

  cau_pkg::ctrl_t ctrl_d   [0:DL-1];
  logic [W-1:0]   fre_d    [0:DL-1];
  logic [W-1:0]   fim_d    [0:DL-1];
  logic           fovf_d   [0:DL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) begin
        ctrl_d[i].valid <= 1'b0;
      end
    end else begin
      ctrl_d[0].valid <= ctrl2.valid;
      for (int i = 1; i < DL; i++) begin
        ctrl_d[i].valid <= ctrl_d[i-1].valid;
      end
    end
    ctrl_d[0].op   <= ctrl2.op;
    ctrl_d[0].zdiv <= ctrl2.zdiv;
    fre_d[0]  <= fre;
    fim_d[0]  <= fim;
    fovf_d[0] <= fovf;
    for (int i = 1; i < DL; i++) begin
      ctrl_d[i].op   <= ctrl_d[i-1].op;
      ctrl_d[i].zdiv <= ctrl_d[i-1].zdiv;
      fre_d[i]  <= fre_d[i-1];
      fim_d[i]  <= fim_d[i-1];
      fovf_d[i] <= fovf_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_d[DL-1].valid;
    end
    zero_divisor <= ctrl_d[DL-1].zdiv;
    if (ctrl_d[DL-1].op == cau_pkg::OP_DIV) begin
      if (ctrl_d[DL-1].zdiv) begin
        res_re        <= '0;
        res_im        <= '0;
        overflow_flag <= 1'b0;
      end else begin
        res_re        <= lre;
        res_im        <= lim;
        overflow_flag <= lre_ovf || lim_ovf;
      end
    end else begin
      res_re        <= fre_d[DL-1];
      res_im        <= fim_d[DL-1];
      overflow_flag <= fovf_d[DL-1];
    end
  end

`ifndef NO_ASSERTIONS
  a_zdiv_clean: assert property (@(posedge clk) disable iff (rst)
    done && zero_divisor |-> (res_re == '0) && (res_im == '0) && !overflow_flag)
    else $error("zero divisor result is not clean");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, W + 6))
    else $error("result word without a request");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    done && overflow_flag |->
      (res_re == RMAX) || (res_re == RMIN) || (res_im == RMAX) || (res_im == RMIN))
    else $error("overflow flagged without a saturated part");
`endif

endmodule
`default_nettype wire
